// ----- sv/ddenc_pkg.sv -----
// Shared types, status codes and width helpers for the delta dictionary encoder.
// Used by ddenc_ctrl, ddenc_dpath and delta_dictionary_encoder; depends on nothing.

package ddenc_pkg;

   // Default sizes handed down from the top level.
   localparam int unsigned DICT_ENTRIES_DEF = 256;
   localparam int unsigned VALUE_BITS_DEF   = 64;

   // Fixed field widths of the channels.
   localparam int unsigned SAMPLE_W = 64;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned COUNT_W  = 21;
   localparam int unsigned CODE_W   = 2;
   localparam int unsigned CSR_W    = 21;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned WIDTH_W  = 7;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_BASE  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEW   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_CODE  = 1'd1;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 21'd65536;
   localparam logic [CODE_W-1:0]  CODE_RESET  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                start_scan;
      logic                scan_step;
      logic                commit;
      logic [STATUS_W-1:0] kind;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_open;
      logic at_limit;
      logic rd_hit;
      logic rd_last;
      logic dict_full;
      logic out_free;
   } stat_type;

   // Element width in bits for a width code, clamped to the stored width.
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [CODE_W-1:0] code,
                                                    input int unsigned vb);
      logic [WIDTH_W-1:0] w;
      w = 7'd8 << code;
      if (vb < 32'(w)) begin
         w = WIDTH_W'(vb);
      end
      return w;
   endfunction

   // Mask of the low w bits of a 64-bit word.
   function automatic logic [SAMPLE_W-1:0] mask64(input logic [WIDTH_W-1:0] w);
      logic [SAMPLE_W-1:0] m;
      if (w >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << w) - 64'd1;
      end
      return m;
   endfunction

   // Sign-extend the low w bits of v to 64 bits.
   function automatic logic [SAMPLE_W-1:0] sext64(input logic [SAMPLE_W-1:0] v,
                                                  input logic [WIDTH_W-1:0]  w);
      logic [SAMPLE_W-1:0] m;
      logic [SAMPLE_W-1:0] r;
      m = mask64(w);
      r = v & m;
      if (w < 7'd64 && v[6'(w - 7'd1)]) begin
         r = r | ~m;
      end
      return r;
   endfunction

endpackage

// ----- sv/ddenc_ctrl.sv -----
// Sequencing state machine of the delta dictionary encoder.
// Depends on ddenc_pkg for the command and status structs and status codes.

module ddenc_ctrl
   import ddenc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EVAL   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [STATUS_W-1:0] kind_ff, kind_in;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cmd            = '0;
      cmd.kind       = kind_ff;
      req_stall      = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (!stat.is_open) begin
               kind_in  = ST_BASE;
               state_in = S_COMMIT;
            end else if (stat.at_limit) begin
               kind_in  = ST_LIMIT;
               state_in = S_COMMIT;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            // The first match wins, so a hit is checked before the end of the scan.
            priority if (stat.rd_hit) begin
               kind_in  = ST_MATCH;
               state_in = S_COMMIT;
            end else if (stat.rd_last) begin
               kind_in  = stat.dict_full ? ST_FULL : ST_NEW;
               state_in = S_COMMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ST_BASE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // An item is only taken while nothing else is in flight.
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == S_IDLE)
      else $error("capture outside idle");

   // A result is written only when the output register can take it.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("commit while output register busy");

   // A scan only starts on an open block below its limit.
   a_scan_open: assert property (@(posedge clock) disable iff (reset)
      cmd.start_scan |-> stat.is_open && !stat.at_limit)
      else $error("scan started on closed or full block");

endmodule

// ----- sv/ddenc_dpath.sv -----
// Datapath of the delta dictionary encoder: configuration, block state,
// dictionary memory, scan compare and output register. Depends on ddenc_pkg.

module ddenc_dpath
   import ddenc_pkg::*;
#(
   parameter int unsigned DICT_ENTRIES = DICT_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   input  logic signed [SAMPLE_W-1:0]  req_sample_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [INDEX_W-1:0]          rsp_dict_index,
   output logic signed [SAMPLE_W-1:0]  rsp_entry_value,
   output logic [COUNT_W-1:0]          rsp_block_count,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_write_data
);

   localparam int unsigned IDX_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(DICT_ENTRIES + 1);
   localparam logic [CNT_W-1:0] DICT_MAX = CNT_W'(DICT_ENTRIES);

   // Configuration.
   logic [COUNT_W-1:0] limit_ff;
   logic [CODE_W-1:0]  code_ff;

   // Block state.
   logic [VALUE_BITS-1:0] prev_ff;
   logic [CNT_W-1:0]      used_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  open_ff;

   // Item under work.
   logic [SAMPLE_W-1:0] x_ff;
   logic [SAMPLE_W-1:0] d_ff;

   // Scan pipeline.
   logic [CNT_W-1:0]      scan_idx_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rd_vld_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [VALUE_BITS-1:0] dict_mem [DICT_ENTRIES];

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [SAMPLE_W-1:0] rsp_entry_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [WIDTH_W-1:0]    eff_w;
   logic [SAMPLE_W-1:0]   mask_w;
   logic [SAMPLE_W-1:0]   delta_w;
   logic                  rd_match;
   logic                  out_free;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic [COUNT_W-1:0]    count_inc;

   assign eff_w     = eff_width(code_ff, VALUE_BITS);
   assign mask_w    = mask64(eff_w);
   assign delta_w   = sext64(x_ff - SAMPLE_W'(prev_ff), eff_w);
   assign rd_match  = ((rd_data_ff ^ d_ff[VALUE_BITS-1:0]) & mask_w[VALUE_BITS-1:0]) == '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_inc = count_ff + 1'b1;

   assign stat.is_open   = open_ff;
   assign stat.at_limit  = (count_ff >= limit_ff);
   assign stat.rd_hit    = rd_vld_ff && rd_match;
   assign stat.rd_last   = rd_vld_ff && (CNT_W'(rd_idx_ff) == used_ff - 1'b1);
   assign stat.dict_full = (used_ff >= DICT_MAX);
   assign stat.out_free  = out_free;

   // The base lands in entry 0, a new delta at the first unused entry.
   assign mem_we    = cmd.commit && (cmd.kind == ST_BASE || cmd.kind == ST_NEW);
   assign mem_waddr = (cmd.kind == ST_BASE) ? '0 : used_ff[IDX_W-1:0];
   assign mem_wdata = (cmd.kind == ST_BASE) ? x_ff[VALUE_BITS-1:0] : d_ff[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= dict_mem[scan_idx_ff[IDX_W-1:0]];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         code_ff  <= CODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_BLOCK_LIMIT: limit_ff <= csr_write_data;
            REG_WIDTH_CODE:  code_ff  <= csr_write_data[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item payload and scan pipeline.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= sext64(req_sample_value, eff_w);
      end
      if (cmd.start_scan) begin
         d_ff <= delta_w;
      end
      if (cmd.commit) begin
         rsp_status_ff <= cmd.kind;
         unique case (cmd.kind)
            ST_BASE: begin
               rsp_index_ff <= '0;
               rsp_entry_ff <= x_ff;
               rsp_count_ff <= COUNT_W'(1);
            end
            ST_MATCH: begin
               rsp_index_ff <= INDEX_W'(rd_idx_ff);
               rsp_entry_ff <= '0;
               rsp_count_ff <= count_inc;
            end
            ST_NEW: begin
               rsp_index_ff <= INDEX_W'(used_ff);
               rsp_entry_ff <= d_ff;
               rsp_count_ff <= count_inc;
            end
            // Both closes report the count of the block that just ended.
            default: begin
               rsp_index_ff <= '0;
               rsp_entry_ff <= '0;
               rsp_count_ff <= count_ff;
            end
         endcase
      end
      if (cmd.scan_step && scan_idx_ff < used_ff) begin
         rd_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start_scan) begin
            scan_idx_ff <= '0;
            rd_vld_ff   <= 1'b0;
         end else if (cmd.scan_step) begin
            rd_vld_ff <= (scan_idx_ff < used_ff);
            if (scan_idx_ff < used_ff) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            unique case (cmd.kind)
               ST_BASE: begin
                  prev_ff  <= x_ff[VALUE_BITS-1:0];
                  used_ff  <= CNT_W'(1);
                  count_ff <= COUNT_W'(1);
                  open_ff  <= 1'b1;
               end
               ST_MATCH: begin
                  prev_ff  <= x_ff[VALUE_BITS-1:0];
                  count_ff <= count_inc;
               end
               ST_NEW: begin
                  prev_ff  <= x_ff[VALUE_BITS-1:0];
                  used_ff  <= used_ff + 1'b1;
                  count_ff <= count_inc;
               end
               ST_FULL, ST_LIMIT: begin
                  open_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_dict_index  = rsp_index_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_block_count = rsp_count_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DICT_MAX)
      else $error("dictionary fill count beyond capacity");

   a_open_used: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> used_ff != '0)
      else $error("open block with empty dictionary");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd.kind == ST_NEW |=> used_ff == $past(used_ff) + 1'b1)
      else $error("new entry did not grow the dictionary");

   a_new_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd.kind == ST_NEW |-> used_ff < DICT_MAX)
      else $error("new entry written into a full dictionary");

endmodule

// ----- sv/delta_dictionary_encoder.sv -----
// Top level of the delta dictionary encoder: joins the controller and the datapath.
// Depends on ddenc_pkg, ddenc_ctrl and ddenc_dpath.
//
// The req channel carries one column value per word; the rsp channel returns
// exactly one result word per value: a status, a dictionary index, the base or
// new delta for the dictionary writer, and the count of values in the block.
// Both channels move a word at a rising edge where valid is high and stall low.
// The csr port writes the block limit (index 0) and the width code (index 1);
// write it only while the block is idle.
// Timing: a value is taken, evaluated in the next cycle, and its result is written
// to the output register in the commit state once that register is free. A base or
// a limit close goes straight from evaluation to commit. Other values search the
// dictionary one entry per cycle through its single read port, from entry 0 until
// a match or the last used entry is read.
// The output register frees the next value from the receiver: a new value is
// taken while a result waits, and only its commit waits for rsp_stall to drop.
// Reset clears the block state (no block open) and loads the default limit of
// 65536 and the 64-bit width code; the dictionary needs no clearing.

module delta_dictionary_encoder
   import ddenc_pkg::*;
#(
   parameter int unsigned DICT_ENTRIES = DICT_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [INDEX_W-1:0]          rsp_dict_index,
   output logic signed [SAMPLE_W-1:0]  rsp_entry_value,
   output logic [COUNT_W-1:0]          rsp_block_count,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences one word at a time through evaluate, scan and commit.
   ddenc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the block state, the dictionary and the output register.
   ddenc_dpath #(
      .DICT_ENTRIES (DICT_ENTRIES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_dict_index   (rsp_dict_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_block_count  (rsp_block_count),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for delta_dictionary_encoder: directed and random column values,
// checked against a behavioral model of the encoder kept inside this file.
// Depends on ddenc_pkg and delta_dictionary_encoder only.

module testbench;
   import ddenc_pkg::*;

   // Clock period is 4 ns; the sender and receiver change their signals at the falling
   // edge, and every handshake is judged at the rising edge.
   localparam int HOLD_CYCLES = 150;   // long receiver hold-off in the backpressure test
   localparam int QUIET_LIMIT = 4000;  // cycles without any accepted word before giving up

   // The result fields of one encoded word, as the encoder should report them.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [SAMPLE_W-1:0] entry;
      logic [COUNT_W-1:0]  count;
   } encoding_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [INDEX_W-1:0]         rsp_dict_index;
   logic signed [SAMPLE_W-1:0] rsp_entry_value;
   logic [COUNT_W-1:0]         rsp_block_count;
   logic                       csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_write_data = '0;

   delta_dictionary_encoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_value(req_sample_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_dict_index  (rsp_dict_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_block_count (rsp_block_count),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #2 clock = ~clock;

   // Model of the encoder. Its configuration copy follows every register write, and its
   // block state follows every accepted input word.
   logic [COUNT_W-1:0]  cfg_limit      = LIMIT_RESET;
   logic [CODE_W-1:0]   cfg_width_code = CODE_RESET;
   logic [SAMPLE_W-1:0] last_value     = '0;
   logic [SAMPLE_W-1:0] delta_dict [DICT_ENTRIES_DEF];
   int unsigned         dict_fill      = 0;
   int unsigned         block_fill     = 0;
   bit                  block_live     = 1'b0;

   // Encodings predicted for accepted words, oldest first, waiting for their result words.
   encoding_type pending_encodings [$];

   int  mismatch_count   = 0;
   int  rsp_words_taken  = 0;
   int  hold_requests    = 0;
   int  quiet_cycles     = 0;
   bit  sender_idle_on   = 1'b1;
   bit  receiver_idle_on = 1'b1;

   function automatic logic [SAMPLE_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Low bits that belong to the element at the width now configured.
   function automatic logic [SAMPLE_W-1:0] lane_mask();
      int unsigned w;
      w = 8 << cfg_width_code;
      if (w >= 64) begin
         return '1;
      end
      return (64'd1 << w) - 64'd1;
   endfunction

   // Keeps the low element bits of v and sign-extends them to 64 bits.
   function automatic logic [SAMPLE_W-1:0] fit_width(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] m;
      int unsigned         w;
      w = 8 << cfg_width_code;
      m = lane_mask();
      v = v & m;
      if (w < 64 && v[w-1]) begin
         v = v | ~m;
      end
      return v;
   endfunction

   // Advances the model by one accepted column value and queues the encoding it implies.
   // The limit test comes before the dictionary search, so a block at its limit closes
   // even when the delta is already known. Entry 0 holds the base and also matches deltas.
   task automatic encode_value(input logic [SAMPLE_W-1:0] raw);
      encoding_type        r;
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] d;
      logic [SAMPLE_W-1:0] m;
      int                  hit_at;
      r = '0;
      m = lane_mask();
      x = fit_width(raw);
      if (!block_live) begin
         delta_dict[0] = x;
         dict_fill = 1;
         block_fill = 1;
         last_value = x;
         block_live = 1'b1;
         r.status = ST_BASE;
         r.entry = x;
      end else if (block_fill >= cfg_limit) begin
         block_live = 1'b0;
         r.status = ST_LIMIT;
      end else begin
         d = fit_width(x - last_value);
         hit_at = -1;
         for (int j = 0; j < dict_fill; j++) begin
            if (((delta_dict[j] ^ d) & m) == '0) begin
               hit_at = j;
               break;
            end
         end
         if (hit_at >= 0) begin
            r.status = ST_MATCH;
            r.index = INDEX_W'(hit_at);
            block_fill++;
            last_value = x;
         end else if (dict_fill >= DICT_ENTRIES_DEF) begin
            block_live = 1'b0;
            r.status = ST_FULL;
         end else begin
            delta_dict[dict_fill] = d;
            r.status = ST_NEW;
            r.index = INDEX_W'(dict_fill);
            r.entry = d;
            dict_fill++;
            block_fill++;
            last_value = x;
         end
      end
      r.count = COUNT_W'(block_fill);
      pending_encodings.push_back(r);
   endtask

   task automatic flag_mismatch(input string field, input logic [SAMPLE_W-1:0] got,
                                input logic [SAMPLE_W-1:0] want);
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Offers one column value after the sender's idle gap and returns at the falling edge
   // after it was taken. Valid is left high so back-to-back words need no extra edge.
   task automatic offer_value(input logic [SAMPLE_W-1:0] v);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_value = v;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      encode_value(v);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_encodings.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Register writes happen only with the encoder idle. Every value produces exactly one
   // result word, so an empty expectation queue means nothing is still in flight.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      wait_drained();
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         REG_BLOCK_LIMIT: cfg_limit = data;
         REG_WIDTH_CODE:  cfg_width_code = data[CODE_W-1:0];
         default: ;
      endcase
   endtask

   // Extreme values at full width: the base, a wrapped delta, a match of a new delta, a
   // zero delta, a delta equal to the base, and a close at the limit on a known delta.
   task automatic test_directed_encoding();
      sender_idle_on = 1'b0;
      offer_value(64'h8000_0000_0000_0000);
      offer_value(64'h7FFF_FFFF_FFFF_FFFF);
      offer_value(64'h7FFF_FFFF_FFFF_FFFE);
      offer_value(64'h7FFF_FFFF_FFFF_FFFE);
      offer_value(64'hFFFF_FFFF_FFFF_FFFE);
      offer_value(64'h0);
      offer_value(64'h0);
      write_csr(REG_BLOCK_LIMIT, CSR_W'(block_fill));
      offer_value(64'h0);
      offer_value(64'h0123_4567_89AB_CDEF);
   endtask

   // A limit of zero still stores the base and then closes; a limit of one behaves the
   // same; the largest limits leave the block open.
   task automatic test_limit_cases();
      sender_idle_on = 1'b1;
      write_csr(REG_BLOCK_LIMIT, '0);
      offer_value(64'h5);
      offer_value(64'hFFFF_FFFF_FFFF_FFFF);
      offer_value(64'h6);
      write_csr(REG_BLOCK_LIMIT, CSR_W'(1));
      offer_value(64'h7);
      offer_value(64'h7);
      write_csr(REG_BLOCK_LIMIT, CSR_W'(21'h100000));
      offer_value(64'h10);
      offer_value(64'h11);
      write_csr(REG_BLOCK_LIMIT, '1);
      offer_value(64'h12);
   endtask

   // Narrow widths ignore the upper input bits, and a width change inside an open block
   // compares the stored entries only on the low bits of the new width.
   task automatic test_width_change();
      write_csr(REG_BLOCK_LIMIT, CSR_W'(LIMIT_RESET));
      write_csr(REG_WIDTH_CODE, CSR_W'(0));
      offer_value(64'h8000_0000_0000_0000);
      offer_value(64'hDEAD_BEEF_CAFE_1280);
      offer_value(64'h1234_5678_9ABC_DE7F);
      write_csr(REG_WIDTH_CODE, CSR_W'(1));
      offer_value(64'hFFFF_0000_0000_007E);
      offer_value(64'h5555_AAAA_5555_FF7E);
      write_csr(REG_WIDTH_CODE, CSR_W'(2));
      offer_value(64'hAAAA_5555_8000_0000);
      write_csr(REG_WIDTH_CODE, CSR_W'(3));
      offer_value(64'h0000_0000_8000_0001);
   endtask

   // Fills all dictionary entries in one block with distinct deltas, matches a deep entry,
   // and then lets one more new delta close the block as full.
   task automatic test_dictionary_full();
      write_csr(REG_BLOCK_LIMIT, '0);
      if (block_live) begin
         offer_value(random_word());
      end
      write_csr(REG_BLOCK_LIMIT, CSR_W'(LIMIT_RESET));
      offer_value(random_word());
      while (block_live && dict_fill < DICT_ENTRIES_DEF) begin
         offer_value(last_value + random_word());
      end
      offer_value(last_value + delta_dict[200]);
      offer_value(last_value + random_word());
      offer_value(random_word());
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the encoder
   // fills up and stalls its input; then the sender waits for every result.
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      write_csr(REG_BLOCK_LIMIT, CSR_W'(12));
      hold_requests++;
      for (int k = 0; k < 40; k++) begin
         offer_value(last_value + 64'($urandom_range(0, 3)));
      end
      wait_drained();
   endtask

   // Phases of random words. Most words continue the block with a delta from a small
   // palette, so blocks grow and matches are common; the rest carry random deltas or
   // unrelated values. Configuration changes between phases without closing the block.
   task automatic test_random_blocks();
      logic [SAMPLE_W-1:0] palette [8];
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] m;
      logic [CSR_W-1:0]    limit;
      int                  palette_len;
      int                  pick;
      for (int phase = 0; phase < 11; phase++) begin
         wait_drained();
         sender_idle_on = ($urandom_range(0, 4) != 0);
         receiver_idle_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 2) != 0) begin
            write_csr(REG_WIDTH_CODE, CSR_W'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 6))
               0:       limit = '0;
               1:       limit = CSR_W'(1);
               2:       limit = CSR_W'($urandom_range(2, 12));
               3:       limit = CSR_W'($urandom_range(13, 300));
               4:       limit = CSR_W'(21'h100000);
               5:       limit = '1;
               default: limit = CSR_W'($urandom);
            endcase
            write_csr(REG_BLOCK_LIMIT, limit);
         end
         palette_len = $urandom_range(1, 6);
         for (int k = 0; k < palette_len; k++) begin
            palette[k] = ($urandom_range(0, 1) != 0) ?
                         64'($urandom_range(0, 8)) - 64'd4 : random_word();
         end
         for (int k = 0; k < 100; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               v = last_value + palette[$urandom_range(0, palette_len - 1)];
            end else if (pick < 92) begin
               v = last_value + random_word();
            end else begin
               v = random_word();
            end
            // Junk above the element width must not change the encoding.
            m = lane_mask();
            v = (v & m) | (random_word() & ~m);
            offer_value(v);
         end
      end
   endtask

   // Receiver: after each taken result word it may hold rsp_stall high for a random stretch,
   // but never in phases without idling. A hold request overrides this with a HOLD_CYCLES hold.
   initial begin
      int seen_taken;
      int holds_served;
      int gap;
      int hold_left;
      seen_taken = 0;
      holds_served = 0;
      gap = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (seen_taken != rsp_words_taken) begin
            seen_taken = rsp_words_taken;
            gap = receiver_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (gap > 0) begin
            rsp_stall = 1'b1;
            gap--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Checks each taken result word, field by field, against the oldest prediction.
   always @(posedge clock) begin : check_results
      encoding_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_words_taken++;
         if (pending_encodings.size() == 0) begin
            flag_mismatch("unexpected word status", SAMPLE_W'(rsp_status), '0);
         end else begin
            want = pending_encodings.pop_front();
            if (rsp_status !== want.status) begin
               flag_mismatch("status", SAMPLE_W'(rsp_status), SAMPLE_W'(want.status));
            end
            if (rsp_dict_index !== want.index) begin
               flag_mismatch("dict_index", SAMPLE_W'(rsp_dict_index), SAMPLE_W'(want.index));
            end
            if (rsp_entry_value !== want.entry) begin
               flag_mismatch("entry_value", rsp_entry_value, want.entry);
            end
            if (rsp_block_count !== want.count) begin
               flag_mismatch("block_count", SAMPLE_W'(rsp_block_count),
                             SAMPLE_W'(want.count));
            end
         end
      end
   end

   // Watchdog: a full-dictionary search plus the longest hold-off and idle gaps stays far
   // below QUIET_LIMIT, so a longer silence means the encoder is stuck.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed_encoding();
      test_limit_cases();
      test_width_change();
      test_dictionary_full();
      test_backpressure();
      test_random_blocks();
      wait_drained();
      // A few more cycles to catch any stray word after the last expected one.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- delta_dictionary_encoder.f -----
sv/ddenc_pkg.sv
sv/ddenc_ctrl.sv
sv/ddenc_dpath.sv
sv/delta_dictionary_encoder.sv
tb/testbench.sv
